>>> design/cso_pkg.sv
// Shared types and constants for the cursor sprite overlay blend unit.
package cso_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_SPRITE_LEFT    = 3'd0,
    REG_SPRITE_TOP     = 3'd1,
    REG_SPRITE_WIDTH   = 3'd2,
    REG_SPRITE_HEIGHT  = 3'd3,
    REG_CURSOR_VISIBLE = 3'd4,
    REG_SCREEN_WIDTH   = 3'd5,
    REG_SCREEN_HEIGHT  = 3'd6
  } cfg_reg_e;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 13;

  localparam logic [12:0] ScreenWidthRst  = 13'd1024;
  localparam logic [12:0] ScreenHeightRst = 13'd768;

  localparam logic [7:0] AlphaMax = 8'hFF;

  // Request types
  localparam logic ReqLoad  = 1'b0;
  localparam logic ReqPixel = 1'b1;

  typedef struct packed {
    logic [12:0] sprite_left;   // two's complement
    logic [12:0] sprite_top;    // two's complement
    logic [5:0]  sprite_width;
    logic [5:0]  sprite_height;
    logic        cursor_visible;
    logic [12:0] screen_width;
    logic [12:0] screen_height;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

>>> design/cso_geom.sv
// Coordinate clipping and sprite store address generation (two stages).
module cso_geom import cso_pkg::*; #(
  parameter int unsigned SPRITE_MAX_W = 32,
  parameter int unsigned SPRITE_MAX_H = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [11:0] pixel_x_i,
  input  logic [11:0] pixel_y_i,
  input  rgb_t        bg_i,
  input  logic [9:0]  sprite_index_i,
  input  logic [31:0] sprite_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        out_pix_o,
  output logic        out_wr_o,
  output logic        out_inside_o,
  output logic [$clog2(SPRITE_MAX_W*SPRITE_MAX_H > 1 ? SPRITE_MAX_W*SPRITE_MAX_H : 2)-1:0]
                      out_addr_o,
  output rgb_t        out_bg_o,
  output logic [31:0] out_word_o
);

  localparam int unsigned Depth = SPRITE_MAX_W * SPRITE_MAX_H;
  localparam int unsigned AW = $clog2(Depth > 1 ? Depth : 2);
  localparam int unsigned CW = $clog2(SPRITE_MAX_W > 1 ? SPRITE_MAX_W : 2);
  localparam int unsigned RW = $clog2(SPRITE_MAX_H > 1 ? SPRITE_MAX_H : 2);
  localparam int unsigned WW = $clog2(SPRITE_MAX_W + 1);
  localparam int unsigned HW = $clog2(SPRITE_MAX_H + 1);

  logic [WW-1:0] w_sat;
  logic [HW-1:0] h_sat;
  logic signed [13:0] cx_s, cy_s;
  logic in_x, in_y, on_x, on_y, in_rect;
  logic rdy0, rdy1;

  // stage 0
  logic          v0_q, pix0_q, inside0_q;
  logic [CW-1:0] cx0_q;
  logic [RW-1:0] cy0_q;
  rgb_t          bg0_q;
  logic [9:0]    idx0_q;
  logic [31:0]   word0_q;

  // stage 1
  logic          v1_q, pix1_q, wr1_q, inside1_q;
  logic [AW-1:0] addr1_q, addr1_d;
  rgb_t          bg1_q;
  logic [31:0]   word1_q;

  always_comb begin
    if (32'(cfg_i.sprite_width) > SPRITE_MAX_W) w_sat = WW'(SPRITE_MAX_W);
    else                                         w_sat = WW'(cfg_i.sprite_width);
    if (32'(cfg_i.sprite_height) > SPRITE_MAX_H) h_sat = HW'(SPRITE_MAX_H);
    else                                          h_sat = HW'(cfg_i.sprite_height);
  end

  assign cx_s = {2'b00, pixel_x_i} - {cfg_i.sprite_left[12], cfg_i.sprite_left};
  assign cy_s = {2'b00, pixel_y_i} - {cfg_i.sprite_top[12], cfg_i.sprite_top};
  assign in_x = !cx_s[13] && (cx_s[12:0] < 13'(w_sat));
  assign in_y = !cy_s[13] && (cy_s[12:0] < 13'(h_sat));
  assign on_x = {1'b0, pixel_x_i} < cfg_i.screen_width;
  assign on_y = {1'b0, pixel_y_i} < cfg_i.screen_height;
  assign in_rect = cfg_i.cursor_visible && on_x && on_y && in_x && in_y;

  assign rdy1 = !v1_q || out_ready_i;
  assign rdy0 = !v0_q || rdy1;
  assign in_ready_o = rdy0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= in_valid_i;
      if (rdy1) v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && in_valid_i) begin
      pix0_q    <= (req_type_i == ReqPixel);
      inside0_q <= in_rect;
      cx0_q     <= CW'(cx_s[12:0]);
      cy0_q     <= RW'(cy_s[12:0]);
      bg0_q     <= bg_i;
      idx0_q    <= sprite_index_i;
      word0_q   <= sprite_word_i;
    end
  end

  // row * stride + column; a load uses its own index
  always_comb begin
    if (pix0_q) addr1_d = AW'(AW'(cy0_q) * AW'(w_sat)) + AW'(cx0_q);
    else        addr1_d = AW'(idx0_q);
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && v0_q) begin
      pix1_q    <= pix0_q;
      wr1_q     <= !pix0_q && (32'(idx0_q) < Depth);
      inside1_q <= inside0_q;
      addr1_q   <= addr1_d;
      bg1_q     <= bg0_q;
      word1_q   <= word0_q;
    end
  end

  assign out_valid_o  = v1_q;
  assign out_pix_o    = pix1_q;
  assign out_wr_o     = wr1_q;
  assign out_inside_o = inside1_q;
  assign out_addr_o   = addr1_q;
  assign out_bg_o     = bg1_q;
  assign out_word_o   = word1_q;

endmodule

>>> design/cso_store.sv
// Sprite store: single-port memory with post-reset clear and registered read.
module cso_store import cso_pkg::*; #(
  parameter int unsigned SPRITE_MAX_W = 32,
  parameter int unsigned SPRITE_MAX_H = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  output logic        busy_o,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        in_pix_i,
  input  logic        in_wr_i,
  input  logic        in_inside_i,
  input  logic [$clog2(SPRITE_MAX_W*SPRITE_MAX_H > 1 ? SPRITE_MAX_W*SPRITE_MAX_H : 2)-1:0]
                      in_addr_i,
  input  rgb_t        in_bg_i,
  input  logic [31:0] in_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        out_inside_o,
  output rgb_t        out_bg_o,
  output logic [31:0] out_word_o
);

  localparam int unsigned Depth = SPRITE_MAX_W * SPRITE_MAX_H;
  localparam int unsigned AW = $clog2(Depth > 1 ? Depth : 2);

  logic [31:0]   mem [Depth];
  logic          clr_q;
  logic [AW-1:0] clr_cnt_q;
  logic          v2_q, inside2_q;
  rgb_t          bg2_q;
  logic [31:0]   rdata_q;
  logic          adv;

  assign in_ready_o = !v2_q || out_ready_i;
  assign adv = in_valid_i && in_ready_o;
  assign busy_o = clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      v2_q      <= 1'b0;
    end else begin
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(Depth - 1)) clr_q <= 1'b0;
      end
      // loads end here
      if (in_ready_o) v2_q <= in_valid_i && in_pix_i;
    end
  end

  // at most one item crosses per cycle, so a cycle either writes or reads
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (adv && in_wr_i) begin
      mem[in_addr_i] <= in_word_i;
    end
    if (adv && in_pix_i) begin
      rdata_q <= mem[in_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_pix_i) begin
      inside2_q <= in_inside_i;
      bg2_q     <= in_bg_i;
    end
  end

  assign out_valid_o  = v2_q;
  assign out_inside_o = inside2_q;
  assign out_bg_o     = bg2_q;
  assign out_word_o   = rdata_q;

endmodule

>>> design/cso_blend.sv
// Alpha blend: products stage, then divide by 255 and output register.
module cso_blend import cso_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        in_inside_i,
  input  rgb_t        in_bg_i,
  input  logic [31:0] in_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rgb_t        out_pix_o,
  output logic        out_hit_o
);

  function automatic logic [15:0] chan_sum(logic [7:0] s, logic [7:0] bg, logic [7:0] a);
    return 16'(s) * 16'(a) + 16'(bg) * 16'(AlphaMax - a);
  endfunction

  // exact x / 255 for x below 255 * 256
  function automatic logic [7:0] div255(logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  logic [7:0]  alpha;
  logic        v3_q, inside3_q, hit3_q;
  logic [15:0] sum_r_q, sum_g_q, sum_b_q;
  rgb_t        bg3_q;
  logic        vo_q, hit_q;
  rgb_t        pix_q, pix_d;
  logic        rdy_o, rdy3;

  assign alpha = in_word_i[31:24];

  assign rdy_o = !vo_q || out_ready_i;
  assign rdy3  = !v3_q || rdy_o;
  assign in_ready_o = rdy3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy3)  v3_q <= in_valid_i;
      if (rdy_o) vo_q <= v3_q;
    end
  end

  // alpha 0 and 255 fall out of the blend formula exactly
  always_ff @(posedge clk_i) begin
    if (rdy3 && in_valid_i) begin
      sum_r_q   <= chan_sum(in_word_i[23:16], in_bg_i.red, alpha);
      sum_g_q   <= chan_sum(in_word_i[15:8], in_bg_i.green, alpha);
      sum_b_q   <= chan_sum(in_word_i[7:0], in_bg_i.blue, alpha);
      inside3_q <= in_inside_i;
      hit3_q    <= in_inside_i && (alpha != 8'd0);
      bg3_q     <= in_bg_i;
    end
  end

  always_comb begin
    if (inside3_q) begin
      pix_d.red   = div255(sum_r_q);
      pix_d.green = div255(sum_g_q);
      pix_d.blue  = div255(sum_b_q);
    end else begin
      pix_d = bg3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && v3_q) begin
      pix_q <= pix_d;
      hit_q <= hit3_q;
    end
  end

  assign out_valid_o = vo_q;
  assign out_pix_o   = pix_q;
  assign out_hit_o   = hit_q;

endmodule

>>> design/cursor_sprite_overlay_blend_unit.sv
// Top level of the cursor sprite overlay blend unit.
//
// Input channel (in_valid_i / in_stall_o): req_type_i = 0 is a load item that
// writes sprite_word_i to sprite_index_i of the sprite store and gives no
// output; req_type_i = 1 is a background pixel that gives one output pixel.
// Output channel (out_valid_o / out_stall_i): blended pixel and cursor_hit_o.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i;
// write only while no item is in flight.
// Throughput is one item per clock while out_stall_i is low and the store is
// not clearing. A pixel passes five register stages (clip, address
// multiply-add, store read, channel products, divide by 255). A load item
// writes the store at the read stage, so later pixels see it and earlier ones
// do not.
// After reset the sprite store is cleared one word per cycle, all
// SPRITE_MAX_W*SPRITE_MAX_H words (1024 by default), with in_stall_o high.
// Configuration registers reset to zero, except screen size 1024 x 768.
// When out_stall_i is high the stages fill up behind the output register and
// in_stall_o rises only once every stage holds an item.
module cursor_sprite_overlay_blend_unit import cso_pkg::*; #(
  parameter int unsigned SPRITE_MAX_W = 32,
  parameter int unsigned SPRITE_MAX_H = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 req_type_i,
  input  logic [11:0]          pixel_x_i,
  input  logic [11:0]          pixel_y_i,
  input  logic [7:0]           bg_blue_i,
  input  logic [7:0]           bg_green_i,
  input  logic [7:0]           bg_red_i,
  input  logic [9:0]           sprite_index_i,
  input  logic [31:0]          sprite_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           out_blue_o,
  output logic [7:0]           out_green_o,
  output logic [7:0]           out_red_o,
  output logic                 cursor_hit_o
);

  localparam int unsigned Depth = SPRITE_MAX_W * SPRITE_MAX_H;
  localparam int unsigned AW = $clog2(Depth > 1 ? Depth : 2);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{sprite_left: '0, sprite_top: '0, sprite_width: '0,
                 sprite_height: '0, cursor_visible: 1'b0,
                 screen_width: ScreenWidthRst, screen_height: ScreenHeightRst};
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_SPRITE_LEFT:    cfg_q.sprite_left    <= cfg_data_i;
        REG_SPRITE_TOP:     cfg_q.sprite_top     <= cfg_data_i;
        REG_SPRITE_WIDTH:   cfg_q.sprite_width   <= cfg_data_i[5:0];
        REG_SPRITE_HEIGHT:  cfg_q.sprite_height  <= cfg_data_i[5:0];
        REG_CURSOR_VISIBLE: cfg_q.cursor_visible <= cfg_data_i[0];
        REG_SCREEN_WIDTH:   cfg_q.screen_width   <= cfg_data_i;
        REG_SCREEN_HEIGHT:  cfg_q.screen_height  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic          busy;
  logic          geo_in_valid, geo_in_ready;
  rgb_t          bg_in;
  logic          g_valid, g_ready, g_pix, g_wr, g_inside;
  logic [AW-1:0] g_addr;
  rgb_t          g_bg;
  logic [31:0]   g_word;
  logic          s_valid, s_ready, s_inside;
  rgb_t          s_bg;
  logic [31:0]   s_word;
  rgb_t          out_pix;

  assign bg_in = '{red: bg_red_i, green: bg_green_i, blue: bg_blue_i};
  assign geo_in_valid = in_valid_i && !busy;
  assign in_stall_o = busy || !geo_in_ready;

  cso_geom #(
    .SPRITE_MAX_W(SPRITE_MAX_W),
    .SPRITE_MAX_H(SPRITE_MAX_H)
  ) u_geom (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (geo_in_valid),
    .in_ready_o    (geo_in_ready),
    .req_type_i    (req_type_i),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .bg_i          (bg_in),
    .sprite_index_i(sprite_index_i),
    .sprite_word_i (sprite_word_i),
    .out_valid_o   (g_valid),
    .out_ready_i   (g_ready),
    .out_pix_o     (g_pix),
    .out_wr_o      (g_wr),
    .out_inside_o  (g_inside),
    .out_addr_o    (g_addr),
    .out_bg_o      (g_bg),
    .out_word_o    (g_word)
  );

  cso_store #(
    .SPRITE_MAX_W(SPRITE_MAX_W),
    .SPRITE_MAX_H(SPRITE_MAX_H)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .busy_o      (busy),
    .in_valid_i  (g_valid),
    .in_ready_o  (g_ready),
    .in_pix_i    (g_pix),
    .in_wr_i     (g_wr),
    .in_inside_i (g_inside),
    .in_addr_i   (g_addr),
    .in_bg_i     (g_bg),
    .in_word_i   (g_word),
    .out_valid_o (s_valid),
    .out_ready_i (s_ready),
    .out_inside_o(s_inside),
    .out_bg_o    (s_bg),
    .out_word_o  (s_word)
  );

  cso_blend u_blend (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_valid),
    .in_ready_o (s_ready),
    .in_inside_i(s_inside),
    .in_bg_i    (s_bg),
    .in_word_i  (s_word),
    .out_valid_o(out_valid_o),
    .out_ready_i(!out_stall_i),
    .out_pix_o  (out_pix),
    .out_hit_o  (cursor_hit_o)
  );

  assign out_blue_o  = out_pix.blue;
  assign out_green_o = out_pix.green;
  assign out_red_o   = out_pix.red;

endmodule
